/* sv/polygon_vertex_convexity_macros.svh */
// assertion macros for the polygon vertex convexity block
// expects clk_i and rst_ni in the scope of each use
`ifndef POLYGON_VERTEX_CONVEXITY_MACROS_SVH
`define POLYGON_VERTEX_CONVEXITY_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pvc_pkg.sv */
// shared types and constants for the polygon vertex convexity block
// payload structs, datapath command and status structs; no dependencies
package pvc_pkg;

  localparam int MaxVerticesDef = 64;
  localparam int CoordBitsDef   = 16;
  localparam int FieldW         = 16;
  localparam int IndexW         = 6;

  typedef struct packed {
    logic signed [FieldW-1:0] vertex_x;
    logic signed [FieldW-1:0] vertex_y;
    logic                     last_vertex;
  } pvc_vertex_t;

  typedef struct packed {
    logic [IndexW-1:0] vertex_index;
    logic              vertex_convex;
    logic              polygon_ccw;
    logic              polygon_convex;
    logic              overflow;
    logic              last_result;
  } pvc_result_t;

  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_LOAD1 = 3'd1,
    MUL_LOAD2 = 3'd2,
    MUL_WRAP1 = 3'd3,
    MUL_WRAP2 = 3'd4,
    MUL_TURN1 = 3'd5,
    MUL_TURN2 = 3'd6
  } pvc_mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_ADD  = 2'd1,
    ACC_SUB  = 2'd2
  } pvc_acc_op_e;

  typedef struct packed {
    pvc_mul_sel_e mul_sel;
    pvc_acc_op_e  acc_op;
    logic         load;
    logic         commit;
    logic         win_init;
    logic         win_fill;
    logic         rd_issue;
    logic         emit;
    logic         clear;
  } pvc_cmd_t;

  typedef struct packed {
    logic mark;
    logic last_index;
  } pvc_status_t;

endpackage

/* sv/polygon_vertex_convexity.sv */
// top level of the polygon vertex convexity classifier
// depends on pvc_pkg, pvc_ctrl, pvc_datapath and the assertion macro header
`include "polygon_vertex_convexity_macros.svh"

// Vertices of one polygon are loaded one transaction at a time with start while busy is
// low; each vertex is taken in S_IDLE and busy stays high through S_LM2 and S_LACC
// while the shared multiplier adds its shoelace terms. The vertex marked last_vertex is
// followed by S_WM1, S_WM2 and S_WACC for the closing term and S_PRE and S_PRE2 to prime
// the read window, then one result per pass through S_CM1, S_CM2 and S_EMIT (two
// multiplies on the single multiplier and the sign test), one per stored vertex in load
// order. Vertices beyond MAX_VERTICES are dropped and reported through overflow.
// result_valid_o is a single-cycle strobe and the receiver cannot stall: each result
// must be taken in the cycle it is shown.
module polygon_vertex_convexity #(
  parameter int MAX_VERTICES = pvc_pkg::MaxVerticesDef,
  parameter int COORD_BITS   = pvc_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pvc_pkg::pvc_vertex_t vertex_i,
  output logic                 result_valid_o,
  output pvc_pkg::pvc_result_t result_o
);
  import pvc_pkg::*;

  pvc_cmd_t    cmd;
  pvc_status_t status;

  pvc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  pvc_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .vertex_i       (vertex_i),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `PVC_ASSERT_NOW(a_result_after_busy, result_valid_o, $past(busy), "result without work")
  `PVC_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "accepted vertex not held")
  `PVC_ASSERT_NEXT(a_last_ends_burst, result_valid_o && result_o.last_result,
                   !result_valid_o, "results past the last one")
  `PVC_ASSERT_NOW(a_convex_only_last, result_valid_o && !result_o.last_result, !result_o.polygon_convex, "polygon_convex before last")

endmodule

/* sv/pvc_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
module pvc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pvc_ctrl.sv */
// sequencer for loading, shoelace sum and per-vertex classification
// depends on pvc_pkg
module pvc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  pvc_pkg::pvc_status_t status_i,
  output logic                busy,
  output pvc_pkg::pvc_cmd_t   cmd_o
);
  import pvc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_LM2  = 11'b000_0000_0010,
    S_LACC = 11'b000_0000_0100,
    S_WM1  = 11'b000_0000_1000,
    S_WM2  = 11'b000_0001_0000,
    S_WACC = 11'b000_0010_0000,
    S_PRE  = 11'b000_0100_0000,
    S_PRE2 = 11'b000_1000_0000,
    S_CM1  = 11'b001_0000_0000,
    S_CM2  = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } pvc_state_e;

  pvc_state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.acc_op  = ACC_HOLD;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load    = 1'b1;
          cmd_o.mul_sel = MUL_LOAD1;
          state_d       = S_LM2;
        end
      end
      S_LM2: begin
        cmd_o.mul_sel = MUL_LOAD2;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = S_LACC;
      end
      S_LACC: begin
        cmd_o.acc_op = ACC_SUB;
        cmd_o.commit = 1'b1;
        state_d      = status_i.mark ? S_WM1 : S_IDLE;
      end
      S_WM1: begin
        cmd_o.mul_sel = MUL_WRAP1;
        state_d       = S_WM2;
      end
      S_WM2: begin
        cmd_o.mul_sel = MUL_WRAP2;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = S_WACC;
      end
      S_WACC: begin
        cmd_o.acc_op = ACC_SUB;
        state_d      = S_PRE;
      end
      S_PRE: begin
        cmd_o.win_init = 1'b1;
        cmd_o.rd_issue = 1'b1;
        state_d        = S_PRE2;
      end
      S_PRE2: begin
        cmd_o.win_fill = 1'b1;
        state_d        = S_CM1;
      end
      S_CM1: begin
        cmd_o.mul_sel  = MUL_TURN1;
        cmd_o.rd_issue = 1'b1;
        state_d        = S_CM2;
      end
      S_CM2: begin
        cmd_o.mul_sel = MUL_TURN2;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.last_index) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_CM1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* sv/pvc_datapath.sv */
// vertex stores, shared multiplier, shoelace accumulator and turn test
// depends on pvc_pkg and pvc_ram
module pvc_datapath #(
  parameter int MAX_VERTICES = pvc_pkg::MaxVerticesDef,
  parameter int COORD_BITS   = pvc_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pvc_pkg::pvc_cmd_t    cmd_i,
  input  pvc_pkg::pvc_vertex_t vertex_i,
  output pvc_pkg::pvc_status_t status_o,
  output logic                 result_valid_o,
  output pvc_pkg::pvc_result_t result_o
);
  import pvc_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int DW    = COORD_BITS + 1;
  localparam int IdxW  = $clog2(MAX_VERTICES);
  localparam int CntW  = $clog2(MAX_VERTICES + 1);
  localparam int LookW = CntW + 1;
  localparam int TurnW = (2 * COORD_BITS + 3 > 64) ? 64 : 2 * COORD_BITS + 3;
  localparam int AccFull = 2 * COORD_BITS + $clog2(MAX_VERTICES) + 2;
  localparam int AccW  = (AccFull > 64) ? 64 : AccFull;

  logic signed [CB-1:0] coord_x, coord_y;
  logic signed [CB-1:0] in_x_q, in_y_q, v0_x_q, v0_y_q, vl_x_q, vl_y_q;
  logic signed [CB-1:0] p_x_q, p_y_q, c_x_q, c_y_q, q_x_q, q_y_q;
  logic [CB-1:0]        rd_x, rd_y;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [IdxW-1:0]      idx_q;
  logic signed [AccW-1:0]  acc_q, acc_d, acc_term;
  logic signed [TurnW-1:0] prod_q, first_q, turn;
  logic signed [DW-1:0]    ax, ay, bx, by, mul_a, mul_b;
  logic signed [2*DW-1:0]  mul_p;
  logic                 stored_now, term_en_now, stored_q, term_en_q, mark_q;
  logic                 mul_zero, reflex_q, ovf_q, ccw_q, valid_q, convex_now, last_index;
  logic [LookW-1:0]     look2, rd_addr;
  logic                 look_ok, rd_ok;
  pvc_result_t          res_q;

  assign coord_x = CB'($signed(vertex_i.vertex_x));
  assign coord_y = CB'($signed(vertex_i.vertex_y));

  assign stored_now  = cnt_q < CntW'(MAX_VERTICES);
  assign term_en_now = stored_now && (cnt_q != '0);

  assign ax = DW'(c_x_q) - DW'(p_x_q);
  assign ay = DW'(c_y_q) - DW'(p_y_q);
  assign bx = DW'(q_x_q) - DW'(c_x_q);
  assign by = DW'(q_y_q) - DW'(c_y_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_LOAD1: begin
        mul_a = DW'(vl_x_q);
        mul_b = DW'(coord_y);
      end
      MUL_LOAD2: begin
        mul_a = DW'(in_x_q);
        mul_b = DW'(vl_y_q);
      end
      MUL_WRAP1: begin
        mul_a = DW'(vl_x_q);
        mul_b = DW'(v0_y_q);
      end
      MUL_WRAP2: begin
        mul_a = DW'(v0_x_q);
        mul_b = DW'(vl_y_q);
      end
      MUL_TURN1: begin
        mul_a = ax;
        mul_b = by;
      end
      MUL_TURN2: begin
        mul_a = ay;
        mul_b = bx;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign mul_zero = ((cmd_i.mul_sel == MUL_LOAD1) && !term_en_now) ||
                    ((cmd_i.mul_sel == MUL_LOAD2) && !term_en_q);

  assign acc_term = AccW'(prod_q);
  always_comb begin
    case (cmd_i.acc_op)
      ACC_ADD: acc_d = acc_q + acc_term;
      ACC_SUB: acc_d = acc_q - acc_term;
      default: acc_d = acc_q;
    endcase
  end

  assign cnt_d = cnt_q + CntW'(1);

  // classification window lookahead
  assign look2   = LookW'(idx_q) + LookW'(2);
  assign look_ok = look2 < LookW'(cnt_q);
  assign rd_addr = cmd_i.win_init ? LookW'(1) : look2;
  assign rd_ok   = rd_addr < LookW'(cnt_q);

  pvc_ram #(.WIDTH(CB), .DEPTH(MAX_VERTICES)) u_x_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && stored_now),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (coord_x),
    .re_i    (cmd_i.rd_issue && rd_ok),
    .raddr_i (rd_addr[IdxW-1:0]),
    .rdata_o (rd_x)
  );

  pvc_ram #(.WIDTH(CB), .DEPTH(MAX_VERTICES)) u_y_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && stored_now),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (coord_y),
    .re_i    (cmd_i.rd_issue && rd_ok),
    .raddr_i (rd_addr[IdxW-1:0]),
    .rdata_o (rd_y)
  );

  assign turn       = first_q - prod_q;
  assign convex_now = (turn == '0) || (ccw_q ? !turn[TurnW-1] : turn[TurnW-1]);
  assign last_index = (CntW'(idx_q) == (cnt_q - CntW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      acc_q    <= '0;
      reflex_q <= 1'b0;
      ovf_q    <= 1'b0;
      mark_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      acc_q   <= acc_d;
      if (cmd_i.load) begin
        mark_q <= vertex_i.last_vertex;
        if (stored_now) begin
          cnt_q <= cnt_d;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.emit && !convex_now) begin
        reflex_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        cnt_q    <= '0;
        acc_q    <= '0;
        reflex_q <= 1'b0;
        ovf_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != MUL_NONE) begin
      prod_q <= mul_zero ? '0 : TurnW'(mul_p);
    end
    if (cmd_i.mul_sel == MUL_TURN2) begin
      first_q <= prod_q;
    end
    if (cmd_i.load) begin
      in_x_q    <= coord_x;
      in_y_q    <= coord_y;
      stored_q  <= stored_now;
      term_en_q <= term_en_now;
    end
    if (cmd_i.commit && stored_q) begin
      vl_x_q <= in_x_q;
      vl_y_q <= in_y_q;
      if (cnt_q == CntW'(1)) begin
        v0_x_q <= in_x_q;
        v0_y_q <= in_y_q;
      end
    end
    if (cmd_i.win_init) begin
      p_x_q <= vl_x_q;
      p_y_q <= vl_y_q;
      c_x_q <= v0_x_q;
      c_y_q <= v0_y_q;
      idx_q <= '0;
      ccw_q <= !acc_q[AccW-1] && (acc_q != '0);
    end
    if (cmd_i.win_fill) begin
      q_x_q <= (cnt_q > CntW'(1)) ? $signed(rd_x) : v0_x_q;
      q_y_q <= (cnt_q > CntW'(1)) ? $signed(rd_y) : v0_y_q;
    end
    if (cmd_i.emit) begin
      p_x_q <= c_x_q;
      p_y_q <= c_y_q;
      c_x_q <= q_x_q;
      c_y_q <= q_y_q;
      q_x_q <= look_ok ? $signed(rd_x) : v0_x_q;
      q_y_q <= look_ok ? $signed(rd_y) : v0_y_q;
      idx_q <= idx_q + IdxW'(1);
      res_q.vertex_index   <= IndexW'(idx_q);
      res_q.vertex_convex  <= convex_now;
      res_q.polygon_ccw    <= ccw_q;
      res_q.polygon_convex <= last_index && !reflex_q && convex_now;
      res_q.overflow       <= ovf_q;
      res_q.last_result    <= last_index;
    end
  end

  assign status_o.mark       = mark_q;
  assign status_o.last_index = last_index;
  assign result_valid_o      = valid_q;
  assign result_o            = res_q;

endmodule
